// ===== rtl/phe_pkg.sv =====
// ----------------------------------------------------------------------------
// phe_pkg
// Shared types, codes and the 32-bit saturation helper for the polynomial
// evaluator with slope.
// ----------------------------------------------------------------------------
package phe_pkg;

  localparam int COEFF_W = 32;
  localparam int ORDER_W = 5;
  localparam int INDEX_W = 4;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } phe_state_t;

  // control from the sequencer to the multiply-add unit
  typedef struct packed {
    logic clr;
    logic step;
    logic first;
    logic slope;
  } phe_mac_ctl_t;

  // {saturation flag, clamped value}
  function automatic logic [COEFF_W:0] sat32(input logic signed [63:0] v);
    logic [COEFF_W:0] res;
    if (v > S32_MAX) begin
      res = {1'b1, S32_MAX[COEFF_W-1:0]};
    end else if (v < S32_MIN) begin
      res = {1'b1, S32_MIN[COEFF_W-1:0]};
    end else begin
      res = {1'b0, v[COEFF_W-1:0]};
    end
    return res;
  endfunction

endpackage

// ===== rtl/phe_cell.sv =====
// ----------------------------------------------------------------------------
// phe_cell
// One coefficient cell of the rotating row: loads a coefficient or takes
// its neighbor's value on a shift.
// ----------------------------------------------------------------------------
module phe_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ld,
  input  logic signed [31:0] ld_data,
  input  logic               shift,
  input  logic signed [31:0] shift_in,
  output logic signed [31:0] q
);

  logic signed [31:0] coeff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
    end else if (ld) begin
      coeff_r <= ld_data;
    end else if (shift) begin
      coeff_r <= shift_in;
    end
  end

  assign q = coeff_r;

endmodule

// ===== rtl/phe_mac.sv =====
// ----------------------------------------------------------------------------
// phe_mac
// Shared Horner step: products are registered first, then truncated, saturated
// and accumulated into value and slope.
// ----------------------------------------------------------------------------
module phe_mac #(
  parameter int FRAC_BITS = 16,
  parameter int KW        = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  phe_pkg::phe_mac_ctl_t ctl,
  input  logic signed [31:0]  x_point,
  input  logic signed [31:0]  coeff,
  input  logic [KW-1:0]       weight,
  output logic signed [31:0]  poly,
  output logic signed [31:0]  slope,
  output logic                sat
);

  import phe_pkg::*;

  localparam int WW = COEFF_W + KW + 1;

  logic                     b_vld_r;
  logic signed [31:0]       x_r;
  logic signed [31:0]       p_r, p_nxt;
  logic signed [31:0]       d_r, d_nxt;
  logic                     flag_r, flag_nxt;
  logic signed [63:0]       prod_p_r, prod_p_nxt;
  logic signed [63:0]       prod_d_r, prod_d_nxt;
  logic signed [WW-1:0]     cw_r, cw_nxt;
  logic signed [31:0]       c_r;
  logic                     first_r;
  logic                     slope_r;
  logic [COEFF_W:0]         cw_s, pm_s, dm_s, ps_s, ds_s;
  logic signed [31:0]       pm_v, dm_v, cw_v;

  assign prod_p_nxt = p_r * x_r;
  assign prod_d_nxt = d_r * x_r;
  assign cw_nxt     = coeff * $signed({1'b0, weight});

  always_comb begin
    cw_s = sat32(64'(cw_r));
    pm_s = sat32(prod_p_r >>> FRAC_BITS);
    dm_s = sat32(prod_d_r >>> FRAC_BITS);
    pm_v = pm_s[COEFF_W-1:0];
    dm_v = dm_s[COEFF_W-1:0];
    cw_v = cw_s[COEFF_W-1:0];
    ps_s = sat32(64'(pm_v) + 64'(c_r));
    ds_s = sat32(64'(dm_v) + 64'(cw_v));
    if (first_r) begin
      p_nxt    = c_r;
      d_nxt    = cw_v;
      flag_nxt = flag_r | cw_s[COEFF_W];
    end else begin
      p_nxt    = ps_s[COEFF_W-1:0];
      flag_nxt = flag_r | pm_s[COEFF_W] | ps_s[COEFF_W];
      if (slope_r) begin
        d_nxt    = ds_s[COEFF_W-1:0];
        flag_nxt = flag_nxt | dm_s[COEFF_W] | cw_s[COEFF_W] | ds_s[COEFF_W];
      end else begin
        d_nxt = d_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= ctl.step;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      prod_p_r <= prod_p_nxt;
      prod_d_r <= prod_d_nxt;
      cw_r     <= cw_nxt;
      c_r      <= coeff;
      first_r  <= ctl.first;
      slope_r  <= ctl.slope;
    end
    if (ctl.clr) begin
      x_r    <= x_point;
      p_r    <= '0;
      d_r    <= '0;
      flag_r <= 1'b0;
    end else if (b_vld_r) begin
      p_r    <= p_nxt;
      d_r    <= d_nxt;
      flag_r <= flag_nxt;
    end
  end

  assign poly  = p_r;
  assign slope = d_r;
  assign sat   = flag_r;

endmodule

// ===== rtl/poly_horner_eval_with_slope.sv =====
// ----------------------------------------------------------------------------
// poly_horner_eval_with_slope
// Fixed-point polynomial value and slope by Horner's scheme over a rotating
// row of coefficient cells feeding one shared multiply-add unit.
//
//   channel   direction   handshake            payload
//   in_       input       in_valid/in_ready    func, coeff_index, coeff_value,
//                                              x_point
//   out_      output      out_valid/out_ready  poly_value, slope_value,
//                                              saturated
//   cfg_      input       cfg_valid/cfg_ready  data (order_in_use)
//
// load transfer: writes the indexed coefficient cell, no result
// evaluate transfer: one rotation of the row through the shared
//   multiply-add unit, each coefficient of the order in use stepping it at
//   the head, then the finish state loads the result into the output register
// synchronous active-low reset clears the coefficient row and the order
// a result waiting on out_ready holds the unit in its finish state; input
//   transfers are taken again once the result is registered
// ----------------------------------------------------------------------------
module poly_horner_eval_with_slope #(
  parameter int MAX_TERMS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_func,
  input  logic [3:0]         in_coeff_index,
  input  logic signed [31:0] in_coeff_value,
  input  logic signed [31:0] in_x_point,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_poly_value,
  output logic signed [31:0] out_slope_value,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_data
);

  import phe_pkg::*;

  localparam int KW = $clog2(MAX_TERMS);
  localparam int NW = $clog2(MAX_TERMS + 1);

  phe_state_t         state_r, state_nxt;
  logic [KW-1:0]      t_r, t_nxt;
  logic               phase_r, phase_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [ORDER_W-1:0] order_r;
  logic               out_valid_r;
  logic signed [31:0] poly_r, slope_r;
  logic               sat_r;

  logic               in_xfer;
  logic               shift_en;
  logic               out_load;
  logic [KW-1:0]      k;
  logic               act;
  phe_mac_ctl_t       mac_ctl;
  logic signed [31:0] mac_poly, mac_slope;
  logic               mac_sat;
  logic signed [31:0] cq [MAX_TERMS];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;

  // coefficient row, rotating toward the head cell
  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    logic ld;
    assign ld = in_xfer && (in_func == FUNC_LOAD) && (32'(in_coeff_index) == i);
    phe_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ld       (ld),
      .ld_data  (in_coeff_value),
      .shift    (shift_en),
      .shift_in (cq[(i + MAX_TERMS - 1) % MAX_TERMS]),
      .q        (cq[i])
    );
  end

  // head cell holds the coefficient of power k
  assign k   = KW'(MAX_TERMS - 1) - t_r;
  assign act = NW'(k) < n_r;

  always_comb begin
    mac_ctl.clr   = in_xfer && (in_func == FUNC_EVAL);
    mac_ctl.step  = (state_r == S_RUN) && !phase_r && act;
    mac_ctl.first = (NW'(k) == n_r - NW'(1));
    mac_ctl.slope = (k != '0);
  end

  phe_mac #(
    .FRAC_BITS (FRAC_BITS),
    .KW        (KW)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .x_point (in_x_point),
    .coeff   (cq[MAX_TERMS-1]),
    .weight  (k),
    .poly    (mac_poly),
    .slope   (mac_slope),
    .sat     (mac_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      t_r     <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      t_r     <= t_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    phase_nxt = phase_r;
    n_nxt     = n_r;
    shift_en  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (mac_ctl.clr) begin
          state_nxt = S_RUN;
          t_nxt     = '0;
          phase_nxt = 1'b0;
          n_nxt     = (32'(order_r) > MAX_TERMS) ? NW'(MAX_TERMS) : NW'(order_r);
        end
      end
      S_RUN: begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          shift_en = 1'b1;
          if (t_r == KW'(MAX_TERMS - 1)) begin
            t_nxt     = '0;
            state_nxt = S_DONE;
          end else begin
            t_nxt = t_r + KW'(1);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      order_r <= cfg_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      poly_r  <= mac_poly;
      slope_r <= mac_slope;
      sat_r   <= mac_sat;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_poly_value  = poly_r;
  assign out_slope_value = slope_r;
  assign out_saturated   = sat_r;

  a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FUNC_EVAL) |=>
      (state_r == S_RUN && t_r == '0 && !phase_r))
    else $error("evaluate transfer did not start a rotation");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FUNC_LOAD) |=> (state_r == S_IDLE))
    else $error("load transfer left idle");

  a_row_restored: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (t_r == '0 && !phase_r))
    else $error("coefficient row not back in place at finish");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside finish state");

endmodule
